>>> rtl/fdadj_pkg.sv
package fdadj_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int MAX_AXIS_LEN = 4096;

  localparam int LEN_W = 13;
  localparam int CNT_W = 4;
  localparam int SCALE_W = 32;
  localparam int ORDER_W = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_AXES = 8;
  localparam int AXIS_W = 3;

  localparam int POS_W = $clog2(MAX_AXIS_LEN + 1);
  localparam int NW = (POS_W > LEN_W) ? POS_W : LEN_W;

  localparam int SUM_W = SAMPLE_WIDTH + 3;
  localparam int MAG_W = (SUM_W > 33) ? SUM_W : 33;
  localparam int HI_W = MAG_W - 32;
  localparam int Q_W = HI_W + 49;

  localparam int REC_DEPTH = 4;
  localparam int REC_PTR_W = $clog2(REC_DEPTH);
  localparam int REC_CNT_W = $clog2(REC_DEPTH + 1);

  localparam int OUT_DEPTH = 8;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_DIFF_ORDER   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ADJOINT_MODE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_LENGTH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_AXIS_COUNT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SCALE   = 3'd4;

  localparam logic [ORDER_W-1:0] ORDER_SECOND = 2'd2;

  typedef struct packed {
    logic [1:0]              nops;
    logic signed [SUM_W-1:0] s0;
    logic signed [SUM_W-1:0] s1;
    logic signed [SUM_W-1:0] s2;
    logic                    eoa;
    logic                    eov;
  } rec_t;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] value;
    logic                    last;
    logic                    eoa;
    logic                    eov;
  } out_t;

endpackage

>>> rtl/fdadj_front.sv
module fdadj_front import fdadj_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           push,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic                           q_full,
  output logic                           rec_push,
  output rec_t                           rec,
  output logic [SCALE_W-1:0]             step_scale
);

  logic [ORDER_W-1:0]             diff_order;
  logic                           adjoint_mode;
  logic [LEN_W-1:0]               axis_length;
  logic [CNT_W-1:0]               axis_count;
  logic signed [SAMPLE_WIDTH-1:0] previous_sample;
  logic signed [SAMPLE_WIDTH-1:0] older_sample;
  logic [POS_W-1:0]               position_in_axis;
  logic [AXIS_W-1:0]              axis_index;

  logic                    accept;
  logic                    cfg_known;
  logic                    k2;
  logic [NW-1:0]           n_raw;
  logic [NW-1:0]           n;
  logic [NW-1:0]           last_pos;
  logic                    at_end;
  logic [CNT_W-1:0]        a;
  logic                    last_axis;
  logic signed [SUM_W-1:0] xe;
  logic signed [SUM_W-1:0] p1e;
  logic signed [SUM_W-1:0] p2e;
  logic signed [SUM_W-1:0] d1;
  logic signed [SUM_W-1:0] d2;
  logic signed [SUM_W-1:0] rd1;
  logic signed [SUM_W-1:0] rd2;
  logic                    emit;

  assign accept = push && !q_full;
  assign cfg_known = (cfg_index == REG_DIFF_ORDER) || (cfg_index == REG_ADJOINT_MODE) ||
                     (cfg_index == REG_AXIS_LENGTH) || (cfg_index == REG_AXIS_COUNT) ||
                     (cfg_index == REG_STEP_SCALE);

  always_comb begin
    k2 = (diff_order == ORDER_SECOND);
    n_raw = NW'(axis_length);
    if (n_raw < NW'(3)) begin
      n = NW'(3);
    end else if (n_raw > NW'(MAX_AXIS_LEN)) begin
      n = NW'(MAX_AXIS_LEN);
    end else begin
      n = n_raw;
    end
    if (adjoint_mode) begin
      last_pos = n - (k2 ? NW'(3) : NW'(2));
    end else begin
      last_pos = n - NW'(1);
    end
    at_end = NW'(position_in_axis) >= last_pos;

    if (axis_count == '0) begin
      a = CNT_W'(1);
    end else if (axis_count > CNT_W'(MAX_AXES)) begin
      a = CNT_W'(MAX_AXES);
    end else begin
      a = axis_count;
    end
    last_axis = (CNT_W'(axis_index) + CNT_W'(1)) >= a;

    xe  = SUM_W'(sample);
    p1e = SUM_W'(previous_sample);
    p2e = SUM_W'(older_sample);
    d1  = xe - p1e;
    d2  = xe - (p1e <<< 1) + p2e;
    rd1 = p1e - xe;
    rd2 = p1e - (xe <<< 1);

    rec.eoa = at_end;
    rec.eov = at_end && last_axis;
    rec.s2  = xe;
    if (adjoint_mode) begin
      emit     = 1'b1;
      rec.s0   = k2 ? d2 : rd1;
      rec.s1   = k2 ? rd2 : xe;
      rec.nops = at_end ? (k2 ? 2'd3 : 2'd2) : 2'd1;
    end else begin
      emit     = NW'(position_in_axis) >= (k2 ? NW'(2) : NW'(1));
      rec.s0   = k2 ? d2 : d1;
      rec.s1   = xe;
      rec.nops = 2'd1;
    end
    rec_push = accept && emit && !cfg_we;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_order       <= ORDER_W'(1);
      adjoint_mode     <= 1'b0;
      axis_length      <= LEN_W'(256);
      axis_count       <= CNT_W'(3);
      step_scale       <= SCALE_W'(65536);
      previous_sample  <= '0;
      older_sample     <= '0;
      position_in_axis <= '0;
      axis_index       <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFF_ORDER:   diff_order   <= cfg_data[ORDER_W-1:0];
        REG_ADJOINT_MODE: adjoint_mode <= cfg_data[0];
        REG_AXIS_LENGTH:  axis_length  <= cfg_data[LEN_W-1:0];
        REG_AXIS_COUNT:   axis_count   <= cfg_data[CNT_W-1:0];
        REG_STEP_SCALE:   step_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
      if (cfg_known) begin
        previous_sample  <= '0;
        older_sample     <= '0;
        position_in_axis <= '0;
        axis_index       <= '0;
      end
    end else if (accept) begin
      if (at_end) begin
        previous_sample  <= '0;
        older_sample     <= '0;
        position_in_axis <= '0;
        axis_index       <= last_axis ? '0 : axis_index + AXIS_W'(1);
      end else begin
        older_sample     <= previous_sample;
        previous_sample  <= sample;
        position_in_axis <= position_in_axis + POS_W'(1);
      end
    end
  end

endmodule

>>> rtl/fdadj_rec_queue.sv
module fdadj_rec_queue import fdadj_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  rec_t wr_data,
  output logic full,
  output logic rd_valid,
  output rec_t rd_data,
  input  logic rd
);

  rec_t                 mem [REC_DEPTH];
  logic [REC_PTR_W-1:0] wr_ptr;
  logic [REC_PTR_W-1:0] rd_ptr;
  logic [REC_CNT_W-1:0] count;
  logic                 do_wr;
  logic                 do_rd;

  assign full     = (count == REC_CNT_W'(REC_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr && !full;
  assign do_rd    = rd && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + REC_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + REC_PTR_W'(1);
      end
      count <= count + REC_CNT_W'(do_wr) - REC_CNT_W'(do_rd);
    end
  end

endmodule

>>> rtl/fdadj_back.sv
module fdadj_back import fdadj_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rec_valid,
  input  rec_t                    rec,
  output logic                    rec_pop,
  input  logic [SCALE_W-1:0]      step_scale,
  input  logic                    pop,
  output logic                    empty,
  output logic [SAMPLE_WIDTH-1:0] value,
  output logic                    last_of_run,
  output logic                    end_of_axis,
  output logic                    end_of_vector
);

  logic [1:0]           idx;
  logic [OUT_CNT_W-1:0] reserved;
  logic                 issue;
  logic                 final_op;
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]     mag_sel;

  // stage 1: sign and magnitude
  logic                 v1;
  logic                 neg1;
  logic [MAG_W-1:0]     mag1;
  logic                 last1;
  logic                 eoa1;
  logic                 eov1;

  // stage 2: partial products
  logic                 v2;
  logic                 neg2;
  logic [63:0]          plo2;
  logic [HI_W+31:0]     phi2;
  logic                 last2;
  logic                 eoa2;
  logic                 eov2;

  // stage 3: round and saturate
  logic [48:0]          rnd;
  logic [Q_W-1:0]       q;
  logic [Q_W-1:0]       limit;
  logic [Q_W-1:0]       qsat;
  logic [SAMPLE_WIDTH-1:0] qs;
  out_t                 res;

  out_t                 mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] count;
  logic                 pop_ok;

  assign issue    = rec_valid && (reserved < OUT_CNT_W'(OUT_DEPTH));
  assign final_op = (idx == rec.nops - 2'd1);
  assign rec_pop  = issue && final_op;
  assign pop_ok   = pop && !empty;
  assign empty    = (count == '0);

  always_comb begin
    case (idx)
      2'd0:    sum_sel = rec.s0;
      2'd1:    sum_sel = rec.s1;
      default: sum_sel = rec.s2;
    endcase
    mag_sel = sum_sel[SUM_W-1] ? (SUM_W'(0) - sum_sel) : sum_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx      <= '0;
      reserved <= '0;
      v1       <= 1'b0;
      v2       <= 1'b0;
    end else begin
      if (issue) begin
        idx <= final_op ? 2'd0 : idx + 2'd1;
      end
      reserved <= reserved + OUT_CNT_W'(issue) - OUT_CNT_W'(pop_ok);
      v1 <= issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    neg1  <= sum_sel[SUM_W-1];
    mag1  <= MAG_W'(mag_sel);
    last1 <= final_op;
    eoa1  <= final_op && rec.eoa;
    eov1  <= final_op && rec.eov;

    neg2  <= neg1;
    plo2  <= 64'(mag1[31:0]) * 64'(step_scale);
    phi2  <= (HI_W+32)'(mag1[MAG_W-1:32]) * (HI_W+32)'(step_scale);
    last2 <= last1;
    eoa2  <= eoa1;
    eov2  <= eov1;
  end

  always_comb begin
    rnd   = 49'(({1'b0, plo2} + 65'h8000) >> 16);
    q     = (Q_W'(phi2) << 16) + Q_W'(rnd);
    limit = Q_W'(1) << (SAMPLE_WIDTH - 1);
    if (neg2) begin
      qsat = (q > limit) ? limit : q;
    end else begin
      qsat = (q > limit - Q_W'(1)) ? limit - Q_W'(1) : q;
    end
    qs        = qsat[SAMPLE_WIDTH-1:0];
    res.value = neg2 ? (SAMPLE_WIDTH'(0) - qs) : qs;
    res.last  = last2;
    res.eoa   = eoa2;
    res.eov   = eov2;
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (v2) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(v2) - OUT_CNT_W'(pop_ok);
    end
  end

  assign value         = mem[rd_ptr].value;
  assign last_of_run   = mem[rd_ptr].last;
  assign end_of_axis   = mem[rd_ptr].eoa;
  assign end_of_vector = mem[rd_ptr].eov;

`ifndef SYNTHESIS
  a_reserved_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= OUT_CNT_W'(OUT_DEPTH))
    else $error("result credit count above queue depth");

  a_count_in_credit: assert property (@(posedge clk) disable iff (rst)
    count <= reserved)
    else $error("result queue holds more beats than were issued");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (count < OUT_CNT_W'(OUT_DEPTH)) || pop_ok)
    else $error("scale pipeline wrote into a full result queue");

  a_pipe_follows_issue: assert property (@(posedge clk) disable iff (rst)
    issue |=> v1)
    else $error("issued op missing from scale pipeline");
`endif

endmodule

>>> rtl/finite_difference_and_adjoint.sv
// Streaming finite-difference operator and its transpose over a vector of up to
// eight concatenated axes. The front end (history, position and axis counters)
// turns each accepted sample into at most one record of one to three stencil
// sums (none for the first samples of a forward axis), which waits in a
// four-entry queue; the back end turns each sum into one result beat through a
// single Q16.16 scale multiplier (sign and magnitude, partial products, round
// and saturate stages) and an eight-entry result queue. A sample is taken
// every cycle while the record queue has room and no configuration write is
// made; the multiplier issues one result per cycle while the result queue has
// room, so the last row of an axis in adjoint mode occupies it for two (first
// difference) or three (second difference) results. Any write to a defined
// configuration register restarts the vector at its first axis.
module finite_difference_and_adjoint import fdadj_pkg::*; (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [CFG_INDEX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]          cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [SAMPLE_WIDTH-1:0] value,
  output logic                           last_of_run,
  output logic                           end_of_axis,
  output logic                           end_of_vector
);

  logic               rec_push;
  rec_t               rec_in;
  logic               rec_full;
  logic               rec_valid;
  rec_t               rec_out;
  logic               rec_pop;
  logic [SCALE_W-1:0] step_scale;
  logic [SAMPLE_WIDTH-1:0] value_bits;

  assign full  = rec_full;
  assign value = signed'(value_bits);

  fdadj_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push       (push),
    .sample     (sample),
    .q_full     (rec_full),
    .rec_push   (rec_push),
    .rec        (rec_in),
    .step_scale (step_scale)
  );

  fdadj_rec_queue u_rec_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (rec_push),
    .wr_data  (rec_in),
    .full     (rec_full),
    .rd_valid (rec_valid),
    .rd_data  (rec_out),
    .rd       (rec_pop)
  );

  fdadj_back u_back (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (rec_valid),
    .rec           (rec_out),
    .rec_pop       (rec_pop),
    .step_scale    (step_scale),
    .pop           (pop),
    .empty         (empty),
    .value         (value_bits),
    .last_of_run   (last_of_run),
    .end_of_axis   (end_of_axis),
    .end_of_vector (end_of_vector)
  );

endmodule
